// File: hdl/acs_pkg.sv
`timescale 1ns / 1ps
package acs_pkg;
  localparam int unsigned LetterW = 5;
  localparam logic [LetterW-1:0] MaxLetter = 5'd25;
  localparam int unsigned Alphabet = 26;
  localparam int unsigned MinLen = 3;
  localparam int unsigned MinKey = 2;

  typedef struct packed {
    logic [4:0] letter;
    logic       is_crib;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [4:0] out_letter;
    logic       solved;
    logic [3:0] key_length;
    logic       end_of_text;
  } out_word_t;

  // (a - b) mod 26 on letter codes; codes above 25 never reach here when solved
  function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + 6'd26 - {1'b0, b};
    if (s >= 6'd26) s = s - 6'd26;
    if (s >= 6'd26) s = s - 6'd26;
    return s[4:0];
  endfunction
endpackage

// File: hdl/acs_front.sv
`timescale 1ns / 1ps
// Accept words and push them into a two-entry queue.
module acs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  acs_pkg::in_word_t data_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output acs_pkg::in_word_t q_data_o
);
  acs_pkg::in_word_t mem_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic push;

  assign stall_o   = (cnt_q == 2'd2);
  assign push      = valid_i && !stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (cnt_q == 2'd2) |-> stall_o)
    else $error("full queue not stalling");
endmodule

// File: hdl/acs_back.sv
`timescale 1ns / 1ps
// Store letters, search for the crib placement, decrypt and stream the text.
module acs_back #(
  parameter int unsigned TEXT_DEPTH = 64,
  parameter int unsigned CRIB_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  acs_pkg::in_word_t  q_data_i,
  output logic               valid_o,
  input  logic               stall_i,
  output acs_pkg::out_word_t data_o
);
  localparam int unsigned TW = $clog2(TEXT_DEPTH + 1);
  localparam int unsigned CW = $clog2(CRIB_DEPTH + 1);
  localparam int unsigned TA = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int unsigned CA = (CRIB_DEPTH > 1) ? $clog2(CRIB_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_LOAD, S_CHK, S_RD, S_CMP, S_PRIM, S_FWD_RD, S_FWD_WR, S_BWD_RD, S_BWD_WR,
    S_OUT_RD, S_OUT
  } state_e;

  state_e state_q;
  logic [4:0] cipher_mem [TEXT_DEPTH];
  logic [4:0] crib_mem   [CRIB_DEPTH];
  logic [4:0] plain_mem  [TEXT_DEPTH];
  logic [TW-1:0] n_q;
  logic [CW-1:0] m_q;
  logic bad_q, solved_q;
  logic [CW-1:0] p_q;
  logic [TW-1:0] i_q, k_q;
  logic [CW-1:0] j_q;
  logic [4:0] ca_q, cb_q, cc_q, pa_q;

  acs_pkg::in_word_t w;
  assign w = q_data_i;
  assign q_pop_o = (state_q == S_LOAD) && q_valid_i;

  // scratch widths wide enough for i + m
  logic [TW+CW:0] im, ij, pj;
  assign im = {{(CW+1){1'b0}}, i_q} + {{(TW+1){1'b0}}, m_q};
  assign ij = {{(CW+1){1'b0}}, i_q} + {{(TW+1){1'b0}}, j_q};
  assign pj = {{(TW+1){1'b0}}, p_q} + {{(TW+1){1'b0}}, j_q};

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && q_valid_i) begin
      if (w.is_crib && m_q < CW'(CRIB_DEPTH)) crib_mem[m_q[CA-1:0]] <= w.letter;
      if (!w.is_crib && n_q < TW'(TEXT_DEPTH)) cipher_mem[n_q[TA-1:0]] <= w.letter;
    end
    if (state_q == S_RD) begin
      ca_q <= cipher_mem[ij[TA-1:0]];
      cb_q <= crib_mem[j_q[CA-1:0]];
      cc_q <= crib_mem[pj[CA-1:0]];
    end
    if (state_q == S_PRIM)
      plain_mem[TA'({{(CW+1){1'b0}}, i_q} - {{(TW+1){1'b0}}, p_q} + {{(TW+1){1'b0}}, j_q})]
        <= crib_mem[j_q[CA-1:0]];
    if (state_q == S_FWD_RD) begin
      ca_q <= cipher_mem[k_q[TA-1:0]];
      pa_q <= plain_mem[TA'(k_q - TW'(p_q))];
    end
    if (state_q == S_FWD_WR) plain_mem[k_q[TA-1:0]] <= acs_pkg::sub26(ca_q, pa_q);
    if (state_q == S_BWD_RD) begin
      ca_q <= cipher_mem[TA'(k_q - 1'b1)];
      pa_q <= plain_mem[TA'(k_q - 1'b1)];
    end
    if (state_q == S_BWD_WR)
      plain_mem[TA'(k_q - 1'b1 - TW'(p_q))] <= acs_pkg::sub26(ca_q, pa_q);
    if (state_q == S_OUT_RD || (state_q == S_OUT && !stall_i)) begin
      ca_q <= cipher_mem[k_q[TA-1:0]];
      pa_q <= plain_mem[k_q[TA-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; n_q <= '0; m_q <= '0; bad_q <= 1'b0; solved_q <= 1'b0;
      p_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0; valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_LOAD: if (q_valid_i) begin
          if (w.is_crib && m_q < CW'(CRIB_DEPTH)) begin
            m_q <= m_q + 1'b1;
            if (w.letter > acs_pkg::MaxLetter) bad_q <= 1'b1;
          end
          if (!w.is_crib && n_q < TW'(TEXT_DEPTH)) begin
            n_q <= n_q + 1'b1;
            if (w.letter > acs_pkg::MaxLetter) bad_q <= 1'b1;
          end
          if (w.last) state_q <= S_CHK;
        end
        S_CHK: begin
          p_q <= CW'(acs_pkg::MinKey);
          i_q <= TW'(acs_pkg::MinKey);
          j_q <= '0;
          solved_q <= 1'b0;
          k_q <= '0;
          if (n_q == '0) begin
            state_q <= S_LOAD; n_q <= '0; m_q <= '0; bad_q <= 1'b0;
          end else if (bad_q || n_q < TW'(acs_pkg::MinLen) || m_q < CW'(acs_pkg::MinLen)
                       || {{(CW+1){1'b0}}, n_q} < {{(TW+1){1'b0}}, m_q}
                       || m_q <= CW'(acs_pkg::MinKey))
            state_q <= S_OUT_RD;
          else state_q <= S_RD;
        end
        S_RD: begin
          if (im > {{(CW+1){1'b0}}, n_q}) begin
            // positions exhausted for this p
            if (p_q + 1'b1 >= m_q) state_q <= S_OUT_RD;
            else begin
              p_q <= p_q + 1'b1; i_q <= TW'(p_q + 1'b1); j_q <= '0;
            end
          end else if (pj >= {{(TW+1){1'b0}}, m_q}) begin
            solved_q <= 1'b1; j_q <= '0; state_q <= S_PRIM;
          end else state_q <= S_CMP;
        end
        S_CMP: begin
          if (acs_pkg::sub26(ca_q, cb_q) == cc_q) j_q <= j_q + 1'b1;
          else begin
            i_q <= i_q + 1'b1; j_q <= '0;
          end
          state_q <= S_RD;
        end
        S_PRIM: begin
          if (j_q + 1'b1 == p_q) begin
            k_q <= i_q; state_q <= S_FWD_RD;
          end
          j_q <= j_q + 1'b1;
        end
        S_FWD_RD: state_q <= (k_q >= n_q) ? S_BWD_RD : S_FWD_WR;
        S_FWD_WR: begin
          if (k_q + 1'b1 >= n_q) begin
            k_q <= i_q; state_q <= S_BWD_RD;
          end else begin
            k_q <= k_q + 1'b1; state_q <= S_FWD_RD;
          end
        end
        S_BWD_RD: begin
          if (k_q <= TW'(p_q)) begin
            k_q <= '0; state_q <= S_OUT_RD;
          end else state_q <= S_BWD_WR;
        end
        S_BWD_WR: begin
          k_q <= k_q - 1'b1; state_q <= S_BWD_RD;
        end
        S_OUT_RD: begin
          valid_o <= 1'b1;
          k_q <= k_q + 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: if (!stall_i) begin
          if (k_q >= n_q) begin
            valid_o <= 1'b0; state_q <= S_LOAD;
            n_q <= '0; m_q <= '0; bad_q <= 1'b0;
          end else k_q <= k_q + 1'b1;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign data_o.out_letter  = solved_q ? pa_q : ca_q;
  assign data_o.solved      = solved_q;
  assign data_o.key_length  = solved_q ? 4'(p_q) : 4'd0;
  assign data_o.end_of_text = (k_q >= n_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> state_q == S_OUT)
    else $error("output valid outside emit phase");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_o |-> state_q == S_LOAD)
    else $error("queue popped while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (valid_o && stall_i) |=> $stable(data_o))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= TW'(TEXT_DEPTH))
    else $error("text count overflow");
endmodule

// File: hdl/autokey_crib_solver.sv
`timescale 1ns / 1ps
// Autokey crib solver. Letters enter at one word per cycle, unless stall_o is raised, through
// a two-word queue and are stored; the word flagged last starts the solve. The search runs
// over all key lengths and positions, comparing one letter at a time; decryption then
// fills in the plaintext, and results leave at one word per cycle unless the receiver
// stalls. Loading resumes when the final result has been taken.
module autokey_crib_solver #(
  parameter int unsigned TEXT_DEPTH = 64,
  parameter int unsigned CRIB_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  acs_pkg::in_word_t  data_i,
  output logic               valid_o,
  input  logic               stall_i,
  output acs_pkg::out_word_t data_o
);
  logic q_valid, q_pop;
  acs_pkg::in_word_t q_data;

  acs_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  acs_back #(.TEXT_DEPTH(TEXT_DEPTH), .CRIB_DEPTH(CRIB_DEPTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .valid_o, .stall_i, .data_o
  );
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

class crib_scoreboard;
  logic [4:0] cipher_mem[64];
  logic [4:0] crib_mem[16];
  logic [4:0] plain_mem[64];
  int unsigned n_cipher;
  int unsigned n_crib;
  bit          bad_code;
  acs_pkg::out_word_t plain_q[$];
  int unsigned n_errors;

  function new();
    n_cipher = 0;
    n_crib = 0;
    bad_code = 0;
    n_errors = 0;
  endfunction

  function automatic logic [4:0] minus26(logic [4:0] a, logic [4:0] b);
    int unsigned s;
    s = (int'(a) + 26 - int'(b)) % 26;
    return s[4:0];
  endfunction

  // First fitting key length, 0 when no placement fits
  function automatic int unsigned find_key(int unsigned n, int unsigned m,
                                           output int unsigned at);
    bit fit;
    at = 0;
    if (m > n) return 0;
    for (int unsigned p = 2; p < m; p++) begin
      for (int unsigned i = p; i + m <= n; i++) begin
        fit = 1;
        for (int unsigned j = 0; j + p < m; j++) begin
          if (minus26(cipher_mem[i+j], crib_mem[j]) != crib_mem[p+j]) begin
            fit = 0;
            break;
          end
        end
        if (fit) begin
          at = i;
          return p;
        end
      end
    end
    return 0;
  endfunction

  function void note_word(acs_pkg::in_word_t w);
    int unsigned n, m, p, at;
    acs_pkg::out_word_t r;
    if (w.is_crib) begin
      if (n_crib < 16) begin
        crib_mem[n_crib] = w.letter;
        n_crib++;
        if (w.letter > acs_pkg::MaxLetter) bad_code = 1;
      end
    end else if (n_cipher < 64) begin
      cipher_mem[n_cipher] = w.letter;
      n_cipher++;
      if (w.letter > acs_pkg::MaxLetter) bad_code = 1;
    end
    if (!w.last) return;
    n = n_cipher;
    m = n_crib;
    p = 0;
    at = 0;
    if (!bad_code && n >= 3 && m >= 3) p = find_key(n, m, at);
    if (p != 0) begin
      for (int unsigned k = 0; k < p; k++) plain_mem[at-p+k] = crib_mem[k];
      for (int unsigned k = at; k < n; k++)
        plain_mem[k] = minus26(cipher_mem[k], plain_mem[k-p]);
      for (int unsigned k = at; k > p; k--)
        plain_mem[k-1-p] = minus26(cipher_mem[k-1], plain_mem[k-1]);
    end
    for (int unsigned k = 0; k < n; k++) begin
      r.out_letter  = (p != 0) ? plain_mem[k] : cipher_mem[k];
      r.solved      = (p != 0);
      r.key_length  = p[3:0];
      r.end_of_text = (k + 1 == n);
      plain_q.push_back(r);
    end
    n_cipher = 0;
    n_crib = 0;
    bad_code = 0;
  endfunction

  function void check_word(acs_pkg::out_word_t got);
    acs_pkg::out_word_t e;
    if (plain_q.size() == 0) begin
      n_errors++;
      if (n_errors <= 10) $display("unexpected word %h", got);
      return;
    end
    e = plain_q.pop_front();
    if (got.out_letter !== e.out_letter || got.solved !== e.solved ||
        got.key_length !== e.key_length || got.end_of_text !== e.end_of_text) begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch: exp letter %0d solved %0d key %0d eot %0d, got %0d %0d %0d %0d",
                 e.out_letter, e.solved, e.key_length, e.end_of_text,
                 got.out_letter, got.solved, got.key_length, got.end_of_text);
    end
  endfunction
endclass

module tb;
  localparam int unsigned CycleLimit = 2000000;

  logic               clk;
  logic               rst_n;
  logic               valid_i;
  logic               stall_o;
  acs_pkg::in_word_t  data_i;
  logic               valid_o;
  logic               stall_i;
  acs_pkg::out_word_t data_o;

  crib_scoreboard sb;
  int unsigned    tx_idle_pct;
  int unsigned    rx_stall_pct;
  bit             hold_go;
  int unsigned    hold_left;
  int unsigned    cycles;
  int unsigned    words_sent;

  autokey_crib_solver DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .data_i  (data_i),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .data_o  (data_o)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_go && hold_left == 0) begin
      hold_left <= 600;
      hold_go <= 0;
      stall_i <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      stall_i <= 1;
    end else begin
      stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && valid_o && !stall_i) sb.check_word(data_o);
  end

  task automatic send_word(acs_pkg::in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      valid_i <= 0;
      @(posedge clk);
    end
    valid_i <= 1;
    data_i <= w;
    @(posedge clk);
    while (stall_o) @(posedge clk);
    sb.note_word(w);
    words_sent++;
  endtask

  // Interleave crib and cipher letters at random; the final word carries last
  task automatic send_msg(logic [4:0] txt[$], logic [4:0] crb[$]);
    int unsigned       ti, ci, total;
    acs_pkg::in_word_t w;
    ti = 0;
    ci = 0;
    total = txt.size() + crb.size();
    for (int unsigned k = 0; k < total; k++) begin
      if (ci < crb.size() && (ti >= txt.size() || $urandom_range(2) == 0)) begin
        w.letter = crb[ci];
        w.is_crib = 1;
        ci++;
      end else begin
        w.letter = txt[ti];
        w.is_crib = 0;
        ti++;
      end
      w.last = (k + 1 == total);
      send_word(w);
    end
  endtask

  // Text-autokey ciphertext with a crib cut from the plaintext
  task automatic send_solvable(int unsigned n, int unsigned m);
    logic [4:0]  plain[$];
    logic [4:0]  txt[$];
    logic [4:0]  crb[$];
    int unsigned p, s, kv;
    p = $urandom_range(2, (m - 1 > 15) ? 15 : m - 1);
    for (int unsigned k = 0; k < n; k++) plain.push_back(5'($urandom_range(25)));
    for (int unsigned k = 0; k < n; k++) begin
      kv = (k < p) ? $urandom_range(25) : plain[k-p];
      txt.push_back(5'((plain[k] + kv) % 26));
    end
    s = $urandom_range(n - m);
    for (int unsigned k = 0; k < m; k++) crb.push_back(plain[s+k]);
    send_msg(txt, crb);
  endtask

  task automatic send_noise(int unsigned n, int unsigned m, bit wild);
    logic [4:0] txt[$];
    logic [4:0] crb[$];
    for (int unsigned k = 0; k < n; k++)
      txt.push_back(5'(wild && $urandom_range(9) == 0 ? $urandom_range(31)
                                                       : $urandom_range(25)));
    for (int unsigned k = 0; k < m; k++)
      crb.push_back(5'(wild && $urandom_range(9) == 0 ? $urandom_range(31)
                                                       : $urandom_range(25)));
    send_msg(txt, crb);
  endtask

  task automatic run_random(int unsigned words);
    int unsigned stop, n, m, pick;
    stop = words_sent + words;
    while (words_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_noise($urandom_range(60, 70), $urandom_range(14, 18), 0);
      end else if (pick < 75) begin
        n = $urandom_range(4, 20);
        m = $urandom_range(3, (n > 8) ? 8 : n);
        send_solvable(n, m);
      end else begin
        send_noise($urandom_range(0, 12), $urandom_range(0, 8), 1);
      end
    end
  endtask

  initial begin
    logic [4:0] txt[$];
    logic [4:0] crb[$];
    sb = new();
    cycles = 0;
    words_sent = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_go = 0;
    hold_left = 0;
    valid_i = 0;
    stall_i = 0;
    data_i = '0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extreme letters in a text that the crib does not fit
    txt = '{5'd0, 5'd25, 5'd0, 5'd25, 5'd1, 5'd24};
    crb = '{5'd25, 5'd0, 5'd25};
    send_msg(txt, crb);
    send_solvable(8, 4);
    // short crib, short text
    txt = '{5'd3, 5'd4, 5'd5};
    crb = '{5'd1, 5'd2};
    send_msg(txt, crb);
    txt = '{5'd3, 5'd4};
    crb = '{5'd1, 5'd2, 5'd3};
    send_msg(txt, crb);
    // crib longer than text
    txt = '{5'd1, 5'd2, 5'd3};
    crb = '{5'd1, 5'd2, 5'd3, 5'd4};
    send_msg(txt, crb);
    // codes above Z
    txt = '{5'd31, 5'd26, 5'd16, 5'd5};
    crb = '{5'd2, 5'd3, 5'd4};
    send_msg(txt, crb);
    // empty text, last on a crib letter
    txt = {};
    crb = '{5'd7};
    send_msg(txt, crb);

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_random(80);
    // long receiver hold-off while the sender keeps offering
    hold_go = 1;
    run_random(45);
    tx_idle_pct = 79;
    rx_stall_pct = 0;
    run_random(125);
    tx_idle_pct = 0;
    rx_stall_pct = 79;
    run_random(125);
    tx_idle_pct = 21;
    rx_stall_pct = 21;
    run_random(125);
    valid_i <= 0;

    while (sb.plain_q.size() != 0) @(posedge clk);
    rx_stall_pct = 0;
    repeat (200) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
